[rtl/pls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    // Geometry and timer size
    localparam int LINES_PER_TURN = 240;
    localparam int TIMER_WIDTH    = 16;

    localparam int LINE_W       = $clog2(LINES_PER_TURN);
    localparam int QUARTER_TURN = LINES_PER_TURN / 4;
    localparam int LEAD_RST     = QUARTER_TURN % LINES_PER_TURN;

    // Turn total is carried as quotient and remainder of this divisor
    localparam int     DIVISOR   = LINES_PER_TURN - 1;
    localparam int     REM_W     = $clog2(DIVISOR);
    localparam longint TIMER_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;
    localparam int     PQ_W      = $clog2(TIMER_MAX / DIVISOR + 2);
    localparam longint RECIP     = (64'd1 << TIMER_WIDTH) / DIVISOR;
    localparam int     RECIP_W   = $clog2(RECIP + 1);
    localparam longint TOTAL_MAX = 64'hFFFF_FFFF;
    localparam longint SAT_Q     = TOTAL_MAX / DIVISOR;
    localparam longint SAT_R     = TOTAL_MAX % DIVISOR;
    localparam int     ACC_Q_W   = $clog2(SAT_Q + TIMER_MAX / DIVISOR + 2);

    // Period smoothing: (7 * old + new) / 8
    localparam int SMOOTH_WEIGHT = 7;
    localparam int SMOOTH_SHIFT  = 3;
    localparam int SMOOTH_W      = ACC_Q_W + SMOOTH_SHIFT;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int FRAME_W    = 40;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'hF0;

    // Reset values
    localparam logic [CFG_DATA_W-1:0] OFFSET_RST = 8'd168;
    localparam logic [CFG_DATA_W-1:0] THRESH_RST = 8'd4;
    localparam longint PERIOD_INIT = 1200;
    localparam longint PERIOD_RST  = (PERIOD_INIT > TIMER_MAX) ? TIMER_MAX : PERIOD_INIT;

    typedef logic [TIMER_WIDTH-1:0] pls_timer_t;
    typedef logic [LINE_W-1:0]      pls_line_t;
    typedef logic [FRAME_W-1:0]     pls_frame_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_HALL  = 2'd1,
        CMD_WRITE = 2'd2
    } pls_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_OFFSET     = 2'd0,
        CFG_RESYNC_THRESHOLD = 2'd1
    } pls_cfg_idx_t;

    // Control from the top level to the period tracker
    typedef struct packed {
        logic step;   // tick below the top: advance the timer
        logic emit;   // tick at the top: restart the timer, add the period
        logic hall;   // hall trigger: new period, clear the total
    } pls_trk_ctl_t;

    typedef struct packed {
        logic       at_top;
        pls_timer_t period;
    } pls_trk_sts_t;

    typedef struct packed {
        logic       en;
        pls_line_t  addr;
        pls_frame_t data;
    } pls_wr_t;

    // Offset register reduced modulo the line count, one entry per code
    localparam int OFF_LUT_DEPTH = 1 << CFG_DATA_W;
    typedef pls_line_t pls_off_lut_t [OFF_LUT_DEPTH];

    function automatic pls_off_lut_t build_off_lut();
        pls_off_lut_t lut;
        for (int i = 0; i < OFF_LUT_DEPTH; i++)
        begin
            lut[i] = LINE_W'(i % LINES_PER_TURN);
        end
        return lut;
    endfunction

    localparam pls_off_lut_t OFF_LUT = build_off_lut();

    function automatic pls_line_t quarter_ahead(pls_line_t l);
        logic [LINE_W:0] s;
        s = (LINE_W+1)'(l) + (LINE_W+1)'(QUARTER_TURN);
        if (s >= (LINE_W+1)'(LINES_PER_TURN))
        begin
            return LINE_W'(s - (LINE_W+1)'(LINES_PER_TURN));
        end
        return LINE_W'(s);
    endfunction

    function automatic pls_line_t step_line(pls_line_t l);
        if (l == LINE_W'(LINES_PER_TURN - 1))
        begin
            return '0;
        end
        return l + 1'b1;
    endfunction

endpackage

`default_nettype wire

[rtl/pls_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pls_in_if;
    import pls_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [IDX_W-1:0]     line_index;
    logic [FRAME_W-1:0]   line_bytes;

    modport source (
        output valid,
        output cmd,
        output line_index,
        output line_bytes,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  line_index,
        input  line_bytes,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pls_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pls_out_if;
    import pls_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FRAME_W-1:0]   frame_bits;
    logic [IDX_W-1:0]     lead_index;
    logic [IDX_W-1:0]     lag_index;
    logic [PERIOD_W-1:0]  period_now;

    modport source (
        output valid,
        output frame_bits,
        output lead_index,
        output lag_index,
        output period_now,
        input  ready
    );

    modport sink (
        input  valid,
        input  frame_bits,
        input  lead_index,
        input  lag_index,
        input  period_now,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pls_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pls_cfg_if;
    import pls_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid,
        output index,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  index,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pls_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module pls_line_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pls_pkg::pls_wr_t    wr,
    input  wire pls_pkg::pls_line_t  lead_addr,
    input  wire pls_pkg::pls_line_t  lag_addr,
    output pls_pkg::pls_frame_t      lead_data,
    output pls_pkg::pls_frame_t      lag_data
);
    import pls_pkg::*;

    pls_frame_t                 line_mem [LINES_PER_TURN];
    logic [LINES_PER_TURN-1:0]  valid_reg;
    pls_frame_t                 lead_rd_reg;
    pls_frame_t                 lag_rd_reg;
    logic                       lead_ok_reg;
    logic                       lag_ok_reg;
    logic                       lead_hit;
    logic                       lag_hit;

    assign lead_hit = wr.en && (wr.addr == lead_addr);
    assign lag_hit  = wr.en && (wr.addr == lag_addr);

    // Write port and two read ports; a write to the address being read is forwarded
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            line_mem[wr.addr] <= wr.data;
        end
        lead_rd_reg <= lead_hit ? wr.data : line_mem[lead_addr];
        lag_rd_reg  <= lag_hit  ? wr.data : line_mem[lag_addr];
    end

    // Entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            lead_ok_reg <= 1'b0;
            lag_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            lead_ok_reg <= lead_hit || valid_reg[lead_addr];
            lag_ok_reg  <= lag_hit  || valid_reg[lag_addr];
        end
    end

    assign lead_data = lead_ok_reg ? lead_rd_reg : '0;
    assign lag_data  = lag_ok_reg  ? lag_rd_reg  : '0;

endmodule

`default_nettype wire

[rtl/pls_period_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module pls_period_track (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pls_pkg::pls_trk_ctl_t             ctl,
    input  wire logic [pls_pkg::CFG_DATA_W-1:0]    threshold,
    output pls_pkg::pls_trk_sts_t                  sts
);
    import pls_pkg::*;

    pls_timer_t timer_count_reg, timer_count_next;
    pls_timer_t timer_top_reg, timer_top_next;
    pls_timer_t period_reg, period_next;

    // Timer count and period, each held as quotient and remainder of DIVISOR
    logic [PQ_W-1:0]    cnt_q_reg, cnt_q_next;
    logic [REM_W-1:0]   cnt_r_reg, cnt_r_next;
    logic [PQ_W-1:0]    per_q_reg, per_q_next;
    logic [REM_W-1:0]   per_r_reg, per_r_next;
    logic               per_sync_reg;

    // Turn total as quotient and remainder
    logic [ACC_Q_W-1:0] acc_q_reg, acc_q_next;
    logic [REM_W-1:0]   acc_r_reg, acc_r_next;

    logic [TIMER_WIDTH+RECIP_W-1:0] recip_prod;
    logic [PQ_W-1:0]                q_est;
    pls_timer_t                     r_est;

    logic [PQ_W-1:0]    add_q;
    logic [REM_W-1:0]   add_r;
    logic [REM_W:0]     r_sum;
    logic               carry;
    logic [REM_W-1:0]   r_wrap;
    logic [ACC_Q_W-1:0] q_sum;
    logic               over;
    logic [ACC_Q_W-1:0] tot_q;
    logic [REM_W-1:0]   tot_r;

    logic [ACC_Q_W-1:0]  old_ext;
    logic [ACC_Q_W-1:0]  diff;
    logic                big;
    logic [SMOOTH_W-1:0] smooth;
    logic [SMOOTH_W-1:0] chosen;
    pls_timer_t          hall_period;

    // Split the period by reciprocal multiply; the estimate is low by at most one
    always_comb
    begin
        recip_prod = (TIMER_WIDTH+RECIP_W)'(period_reg) * (TIMER_WIDTH+RECIP_W)'(RECIP);
        q_est      = PQ_W'(recip_prod >> TIMER_WIDTH);
        r_est      = period_reg - TIMER_WIDTH'(q_est * DIVISOR);
        if (r_est >= TIMER_WIDTH'(DIVISOR))
        begin
            per_q_next = q_est + 1'b1;
            per_r_next = REM_W'(r_est - TIMER_WIDTH'(DIVISOR));
        end
        else
        begin
            per_q_next = q_est;
            per_r_next = REM_W'(r_est);
        end
    end

    // Add to the turn total and saturate
    always_comb
    begin
        if (ctl.hall)
        begin
            add_q = cnt_q_reg;
            add_r = cnt_r_reg;
        end
        else if (per_sync_reg)
        begin
            add_q = per_q_reg;
            add_r = per_r_reg;
        end
        else
        begin
            // split not yet refreshed: only a one-tick period can emit here
            add_q = '0;
            add_r = REM_W'(1);
        end
        r_sum  = {1'b0, acc_r_reg} + {1'b0, add_r};
        carry  = r_sum >= (REM_W+1)'(DIVISOR);
        r_wrap = carry ? REM_W'(r_sum - (REM_W+1)'(DIVISOR)) : REM_W'(r_sum);
        q_sum  = acc_q_reg + ACC_Q_W'(add_q) + ACC_Q_W'(carry);
        over   = (q_sum > ACC_Q_W'(SAT_Q))
              || ((q_sum == ACC_Q_W'(SAT_Q)) && (r_wrap > REM_W'(SAT_R)));
        tot_q  = over ? ACC_Q_W'(SAT_Q) : q_sum;
        tot_r  = over ? REM_W'(SAT_R) : r_wrap;
    end

    // New period on a hall trigger: adopt or smooth, then clamp
    always_comb
    begin
        old_ext = ACC_Q_W'(period_reg);
        diff    = (tot_q > old_ext) ? (tot_q - old_ext) : (old_ext - tot_q);
        big     = diff > ACC_Q_W'(threshold);
        smooth  = SMOOTH_W'((SMOOTH_W'(period_reg) * SMOOTH_WEIGHT + SMOOTH_W'(tot_q))
                  >> SMOOTH_SHIFT);
        chosen  = big ? SMOOTH_W'(tot_q) : smooth;
        if (chosen == '0)
        begin
            hall_period = TIMER_WIDTH'(1);
        end
        else if (64'(chosen) > TIMER_MAX)
        begin
            hall_period = TIMER_WIDTH'(TIMER_MAX);
        end
        else
        begin
            hall_period = TIMER_WIDTH'(chosen);
        end
    end

    always_comb
    begin
        timer_count_next = timer_count_reg;
        timer_top_next   = timer_top_reg;
        period_next      = period_reg;
        cnt_q_next       = cnt_q_reg;
        cnt_r_next       = cnt_r_reg;
        acc_q_next       = acc_q_reg;
        acc_r_next       = acc_r_reg;
        if (ctl.hall)
        begin
            timer_count_next = '0;
            cnt_q_next       = '0;
            cnt_r_next       = '0;
            acc_q_next       = '0;
            acc_r_next       = '0;
            period_next      = hall_period;
            timer_top_next   = hall_period - 1'b1;
        end
        else if (ctl.emit)
        begin
            timer_count_next = '0;
            cnt_q_next       = '0;
            cnt_r_next       = '0;
            acc_q_next       = tot_q;
            acc_r_next       = tot_r;
        end
        else if (ctl.step)
        begin
            timer_count_next = timer_count_reg + 1'b1;
            if (cnt_r_reg == REM_W'(DIVISOR - 1))
            begin
                cnt_r_next = '0;
                cnt_q_next = cnt_q_reg + 1'b1;
            end
            else
            begin
                cnt_r_next = cnt_r_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_count_reg <= '0;
            timer_top_reg   <= TIMER_WIDTH'(PERIOD_RST);
            period_reg      <= TIMER_WIDTH'(PERIOD_RST);
            cnt_q_reg       <= '0;
            cnt_r_reg       <= '0;
            acc_q_reg       <= '0;
            acc_r_reg       <= '0;
            per_sync_reg    <= 1'b0;
        end
        else
        begin
            timer_count_reg <= timer_count_next;
            timer_top_reg   <= timer_top_next;
            period_reg      <= period_next;
            cnt_q_reg       <= cnt_q_next;
            cnt_r_reg       <= cnt_r_next;
            acc_q_reg       <= acc_q_next;
            acc_r_reg       <= acc_r_next;
            per_sync_reg    <= !ctl.hall;
        end
    end

    always_ff @(posedge clk)
    begin
        per_q_reg <= per_q_next;
        per_r_reg <= per_r_next;
    end

    assign sts.at_top = timer_count_reg >= timer_top_reg;
    assign sts.period = period_reg;

    a_count_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        timer_count_reg <= timer_top_reg)
        else $error("timer count passed its top value");

    a_remainders_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_r_reg < REM_W'(DIVISOR)) && (cnt_r_reg < REM_W'(DIVISOR)))
        else $error("remainder not reduced below divisor");

    a_stale_split_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit && !per_sync_reg |-> period_reg == TIMER_WIDTH'(1))
        else $error("emit used a stale period split");

endmodule

`default_nettype wire

[rtl/pov_line_sync_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake       Word
// item     in   valid / ready   cmd, line_index, line_bytes
// result   out  valid / ready   frame_bits, lead_index, lag_index, period_now
// cfg      in   valid / ready   index, data (ready tied high)
//
// One word a cycle while item.ready is high: a word is taken in the cycle it arrives
// and its frame, if any, sits in the result register the next cycle.
// The line store is read ahead at the next lead and lag lines, so frame data is ready
// in the cycle a tick reaches the timer top.
// item.ready falls only while a frame waits in the result register and result.ready
// is low; stall there and the timer stops with it.
// Reset clears the line store through per-line valid bits; no clearing pass.
module pov_line_sync_scanner (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pls_in_if.sink      item,
    pls_out_if.source   result,
    pls_cfg_if.sink     cfg
);
    import pls_pkg::*;

    logic [CFG_DATA_W-1:0] angle_offset_reg;
    logic [CFG_DATA_W-1:0] resync_threshold_reg;

    pls_line_t lead_reg, lead_next;
    pls_line_t lag_reg, lag_next;
    pls_line_t offset_line;
    pls_line_t lead_of_lag;

    logic         accept;
    logic         is_tick;
    logic         emit;
    pls_trk_ctl_t trk_ctl;
    pls_trk_sts_t trk_sts;
    pls_wr_t      wr;

    pls_frame_t lead_data;
    pls_frame_t lag_data;
    pls_frame_t frame;

    logic                 result_valid_reg;
    pls_frame_t           frame_reg;
    logic [IDX_W-1:0]     lead_index_reg;
    logic [IDX_W-1:0]     lag_index_reg;
    logic [PERIOD_W-1:0]  period_now_reg;

    // Take a word unless a frame is held and the sink is stalled
    assign item.ready = !result_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Decode the command
    always_comb
    begin
        is_tick      = item.cmd == CMD_TICK;
        emit         = accept && is_tick && trk_sts.at_top;
        trk_ctl.step = accept && is_tick && !trk_sts.at_top;
        trk_ctl.emit = emit;
        trk_ctl.hall = accept && (item.cmd == CMD_HALL);
        wr.en        = accept && (item.cmd == CMD_WRITE)
                    && (int'(item.line_index) < LINES_PER_TURN);
        wr.addr      = LINE_W'(item.line_index);
        wr.data      = item.line_bytes;
    end

    // Line counters: reload from the offset on a hall trigger, advance on each frame
    assign offset_line = OFF_LUT[angle_offset_reg];
    assign lead_of_lag = quarter_ahead(lag_reg);

    always_comb
    begin
        lead_next = lead_reg;
        lag_next  = lag_reg;
        if (trk_ctl.hall)
        begin
            lag_next  = offset_line;
            lead_next = quarter_ahead(offset_line);
        end
        else if (emit)
        begin
            lag_next  = step_line(lag_reg);
            lead_next = step_line(lead_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= LINE_W'(LEAD_RST);
            lag_reg  <= '0;
        end
        else
        begin
            lead_reg <= lead_next;
            lag_reg  <= lag_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_offset_reg     <= OFFSET_RST;
            resync_threshold_reg <= THRESH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ANGLE_OFFSET:     angle_offset_reg     <= cfg.data;
                CFG_RESYNC_THRESHOLD: resync_threshold_reg <= cfg.data;
                default:              ;
            endcase
        end
    end

    pls_period_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (trk_ctl),
        .threshold (resync_threshold_reg),
        .sts       (trk_sts)
    );

    // Read at the next counter values so the data matches the current ones
    pls_line_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .lead_addr (lead_next),
        .lag_addr  (lag_next),
        .lead_data (lead_data),
        .lag_data  (lag_data)
    );

    // Frame, top byte first: lag bytes 4 and 3, mixed byte 2, lead bytes 1 and 0
    always_comb
    begin
        frame = {lag_data[4*BYTE_W +: BYTE_W],
                 lag_data[3*BYTE_W +: BYTE_W],
                 (lead_data[2*BYTE_W +: BYTE_W] & LOW_NIBBLE)
                     | (lag_data[2*BYTE_W +: BYTE_W] & HIGH_NIBBLE),
                 lead_data[1*BYTE_W +: BYTE_W],
                 lead_data[0 +: BYTE_W]};
    end

    // Result register: load on a frame, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frame_reg      <= frame;
            lead_index_reg <= IDX_W'(lead_reg);
            lag_index_reg  <= IDX_W'(lag_reg);
            period_now_reg <= PERIOD_W'(trk_sts.period);
        end
    end

    assign result.valid      = result_valid_reg;
    assign result.frame_bits = frame_reg;
    assign result.lead_index = lead_index_reg;
    assign result.lag_index  = lag_index_reg;
    assign result.period_now = period_now_reg;

    a_lead_quarter_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg == lead_of_lag)
        else $error("lead line lost its quarter-turn spacing");

    a_emit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> result_valid_reg)
        else $error("frame not held after emit");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result.ready |=> result_valid_reg && $stable(frame_reg))
        else $error("waiting frame changed before it was taken");

endmodule

`default_nettype wire
